>>> hdl/mftt_pkg.sv
package mftt_pkg;

    localparam int AngleWidth = 13;
    localparam int TurnWidth  = 32;

    localparam logic [1:0] MODE_FEEDBACK = 2'd0;
    localparam logic [1:0] MODE_TICK     = 2'd1;
    localparam logic [1:0] MODE_ADD      = 2'd2;
    localparam logic [1:0] MODE_SET      = 2'd3;

    localparam logic [1:0] LINK_DISABLED     = 2'd0;
    localparam logic [1:0] LINK_CONNECTED    = 2'd1;
    localparam logic [1:0] LINK_DISCONNECTED = 2'd2;

    localparam logic signed [AngleWidth+1:0] JUMP_LIMIT = 15'sd4191;
    localparam logic [7:0] OFFLINE_LIMIT_RESET = 8'd40;
    localparam logic [7:0] SILENCE_MAX = 8'hFF;

    typedef struct packed {
        logic [1:0]                   mode;
        logic [AngleWidth-1:0]        angle_reading;
        logic signed [15:0]           speed_reading;
        logic signed [15:0]           current_reading;
        logic [7:0]                   temperature_reading;
        logic signed [TurnWidth-1:0]  target_value;
    } in_word_t;

    typedef struct packed {
        logic [1:0]                   link_state;
        logic [AngleWidth-1:0]        current_angle;
        logic signed [TurnWidth-1:0]  turn_count;
        logic signed [15:0]           current_speed;
        logic signed [15:0]           current_draw;
        logic [7:0]                   current_temperature;
        logic [AngleWidth-1:0]        target_angle;
        logic signed [TurnWidth-1:0]  target_turns;
        logic                         clear_controllers;
    } out_word_t;

    typedef struct packed {
        logic [1:0]                   link_mode;
        logic [7:0]                   silence_count;
        logic [AngleWidth-1:0]        last_angle;
        logic signed [TurnWidth-1:0]  turns;
        logic signed [15:0]           last_speed;
        logic signed [15:0]           last_current;
        logic [7:0]                   last_temperature;
        logic [AngleWidth-1:0]        goal_angle;
        logic signed [TurnWidth-1:0]  goal_turns;
    } track_state_t;

endpackage

>>> hdl/motor_feedback_turn_tracker_top.sv
// Turn tracker for one motor feedback link. Every accepted word (feedback frame,
// timer tick, target offset or absolute target) yields exactly one result word
// with the full tracked state after the update. A word is taken every cycle
// unless the output stalls; an input register feeds the result register, with the
// whole state update done in the single logic stage between them. The offline
// limit (reset 40) must be written through the configuration channel while the
// block is idle; the block does not enforce this. cfg_ready is always high.
module motor_feedback_turn_tracker_top
    import mftt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  in_word_t   in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output out_word_t  out_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    logic         in_valid_reg;
    in_word_t     in_data_reg;
    logic         out_valid_reg;
    out_word_t    out_data_reg;
    track_state_t state_reg;
    track_state_t state_next;
    logic         clear_next;
    logic [7:0]   limit_reg;
    logic         out_free;
    logic         advance;

    assign out_free  = !out_valid_reg || !out_stall;
    assign advance   = in_valid_reg && out_free;
    assign in_stall  = in_valid_reg && !out_free;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign cfg_ready = 1'b1;

    mftt_update u_update (
        .cur_state     (state_reg),
        .word          (in_data_reg),
        .offline_limit (limit_reg),
        .state_next    (state_next),
        .clear_next    (clear_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
            limit_reg     <= OFFLINE_LIMIT_RESET;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_data_reg <= in_data;
        end
        if (advance)
        begin
            out_data_reg.link_state          <= state_next.link_mode;
            out_data_reg.current_angle       <= state_next.last_angle;
            out_data_reg.turn_count          <= state_next.turns;
            out_data_reg.current_speed       <= state_next.last_speed;
            out_data_reg.current_draw        <= state_next.last_current;
            out_data_reg.current_temperature <= state_next.last_temperature;
            out_data_reg.target_angle        <= state_next.goal_angle;
            out_data_reg.target_turns        <= state_next.goal_turns;
            out_data_reg.clear_controllers   <= clear_next;
        end
    end

    a_clear_means_down: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.clear_controllers |-> out_data.link_state == LINK_DISCONNECTED)
        else $error("clear_controllers without disconnected link");

    a_feedback_connects: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_data_reg.mode == MODE_FEEDBACK
        |=> state_reg.link_mode == LINK_CONNECTED && state_reg.silence_count == 8'd0)
        else $error("feedback did not connect link");

    a_turns_only_on_feedback: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(state_reg.turns) |-> $past(advance && in_data_reg.mode == MODE_FEEDBACK))
        else $error("turn count changed without feedback");

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg && out_valid_reg)
        else $error("input stalled with free pipeline");

endmodule

>>> hdl/mftt_update.sv
module mftt_update
    import mftt_pkg::*;
(
    input  track_state_t cur_state,
    input  in_word_t     word,
    input  logic [7:0]   offline_limit,
    output track_state_t state_next,
    output logic         clear_next
);

    logic signed [AngleWidth+1:0] angle_step;
    logic [7:0]                   silence_bump;
    logic [AngleWidth:0]          angle_sum;
    logic [TurnWidth-1:0]         offset_turns;

    assign angle_step = $signed({2'b00, word.angle_reading})
                      - $signed({2'b00, cur_state.last_angle});
    assign silence_bump = (cur_state.silence_count != SILENCE_MAX)
                        ? cur_state.silence_count + 8'd1 : cur_state.silence_count;
    assign angle_sum = {1'b0, cur_state.goal_angle} + {1'b0, word.target_value[AngleWidth-1:0]};
    assign offset_turns = {{AngleWidth{word.target_value[TurnWidth-1]}},
                           word.target_value[TurnWidth-1:AngleWidth]};

    always_comb
    begin
        state_next = cur_state;
        clear_next = 1'b0;
        case (word.mode)
            MODE_FEEDBACK:
            begin
                if (angle_step > JUMP_LIMIT)
                begin
                    state_next.turns = cur_state.turns - 32'sd1;
                end
                else if (angle_step < -JUMP_LIMIT)
                begin
                    state_next.turns = cur_state.turns + 32'sd1;
                end
                if (cur_state.link_mode == LINK_DISCONNECTED)
                begin
                    state_next.goal_angle = word.angle_reading;
                    state_next.goal_turns = '0;
                end
                state_next.silence_count    = '0;
                state_next.link_mode        = LINK_CONNECTED;
                state_next.last_angle       = word.angle_reading;
                state_next.last_speed       = word.speed_reading;
                state_next.last_current     = word.current_reading;
                state_next.last_temperature = word.temperature_reading;
            end
            MODE_TICK:
            begin
                if (silence_bump > offline_limit)
                begin
                    state_next.silence_count = offline_limit + 8'd1;
                    state_next.link_mode     = LINK_DISCONNECTED;
                    clear_next               = 1'b1;
                end
                else
                begin
                    state_next.silence_count = silence_bump;
                end
            end
            MODE_ADD:
            begin
                state_next.goal_angle = angle_sum[AngleWidth-1:0];
                state_next.goal_turns = cur_state.goal_turns + offset_turns
                                      + {{(TurnWidth-1){1'b0}}, angle_sum[AngleWidth]};
            end
            default:
            begin
                state_next.goal_angle = word.target_value[AngleWidth-1:0];
                state_next.goal_turns = offset_turns;
            end
        endcase
    end

endmodule

>>> tb/turn_tracker_checker.sv
`timescale 1ns / 1ps

module turn_tracker_checker
    import mftt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  in_word_t   in_data,
    input  logic       out_valid,
    input  logic       out_stall,
    input  out_word_t  out_data,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [7:0] cfg_data,
    output int         mismatches,
    output int         outstanding
);

    track_state_t tracked;
    logic [7:0]   timeout_limit;
    out_word_t    expected_words[$];
    out_word_t    oldest;

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0h, want %0h", name, got, want));
    endtask

    function automatic out_word_t advance_tracker(input in_word_t w);
        out_word_t   r;
        int          angle_step;
        logic [63:0] goal_pos;
        logic        clear;
        clear    = 1'b0;
        goal_pos = '0;
        case (w.mode)
            MODE_FEEDBACK:
            begin
                angle_step = int'(w.angle_reading) - int'(tracked.last_angle);
                if (angle_step > JUMP_LIMIT)
                    tracked.turns = tracked.turns - 1;
                else if (angle_step < -JUMP_LIMIT)
                    tracked.turns = tracked.turns + 1;
                if (tracked.link_mode == LINK_DISCONNECTED)
                begin
                    tracked.goal_angle = w.angle_reading;
                    tracked.goal_turns = '0;
                end
                tracked.silence_count    = '0;
                tracked.link_mode        = LINK_CONNECTED;
                tracked.last_angle       = w.angle_reading;
                tracked.last_speed       = w.speed_reading;
                tracked.last_current     = w.current_reading;
                tracked.last_temperature = w.temperature_reading;
            end
            MODE_TICK:
            begin
                if (tracked.silence_count != SILENCE_MAX)
                    tracked.silence_count = tracked.silence_count + 8'd1;
                if (tracked.silence_count > timeout_limit)
                begin
                    tracked.silence_count = timeout_limit + 8'd1;
                    tracked.link_mode     = LINK_DISCONNECTED;
                    clear                 = 1'b1;
                end
            end
            MODE_ADD:
            begin
                goal_pos = {{32{tracked.goal_turns[31]}}, tracked.goal_turns} << 13;
                goal_pos = goal_pos + {51'd0, tracked.goal_angle}
                         + {{32{w.target_value[31]}}, w.target_value};
            end
            default:
            begin
                goal_pos = {{32{w.target_value[31]}}, w.target_value};
            end
        endcase
        // floor split: low 13 bits are the angle, the rest the turns
        if (w.mode inside {MODE_ADD, MODE_SET})
        begin
            tracked.goal_angle = goal_pos[12:0];
            tracked.goal_turns = goal_pos[44:13];
        end
        r.link_state          = tracked.link_mode;
        r.current_angle       = tracked.last_angle;
        r.turn_count          = tracked.turns;
        r.current_speed       = tracked.last_speed;
        r.current_draw        = tracked.last_current;
        r.current_temperature = tracked.last_temperature;
        r.target_angle        = tracked.goal_angle;
        r.target_turns        = tracked.goal_turns;
        r.clear_controllers   = clear;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tracked       = '0;
            timeout_limit = OFFLINE_LIMIT_RESET;
            expected_words.delete();
            mismatches    = 0;
            outstanding   = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                    report_mismatch("result word with no input word waiting");
                else
                begin
                    oldest = expected_words.pop_front();
                    check_field("link_state", out_data.link_state, oldest.link_state);
                    check_field("current_angle", out_data.current_angle,
                                oldest.current_angle);
                    check_field("turn_count", out_data.turn_count, oldest.turn_count);
                    check_field("current_speed", out_data.current_speed,
                                oldest.current_speed);
                    check_field("current_draw", out_data.current_draw,
                                oldest.current_draw);
                    check_field("current_temperature", out_data.current_temperature,
                                oldest.current_temperature);
                    check_field("target_angle", out_data.target_angle,
                                oldest.target_angle);
                    check_field("target_turns", out_data.target_turns,
                                oldest.target_turns);
                    check_field("clear_controllers", out_data.clear_controllers,
                                oldest.clear_controllers);
                end
            end
            if (cfg_valid && cfg_ready)
                timeout_limit = cfg_data;
            if (in_valid && !in_stall)
                expected_words.push_back(advance_tracker(in_data));
            outstanding = expected_words.size();
        end
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import mftt_pkg::*;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    in_word_t   in_data;
    logic       out_valid;
    logic       out_stall;
    out_word_t  out_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_data;

    int         mismatches;
    int         outstanding;
    logic       calm;
    int         hold_request;
    int         sweep_angle;
    logic [7:0] limit_now;
    in_word_t   opening_words[$];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    motor_feedback_turn_tracker_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    turn_tracker_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    function automatic in_word_t pack_word(input logic [1:0] mode, input int angle,
                                           input int speed, input int current,
                                           input int temp, input int target);
        in_word_t w;
        w.mode                = mode;
        w.angle_reading       = 13'(angle);
        w.speed_reading       = 16'(speed);
        w.current_reading     = 16'(current);
        w.temperature_reading = 8'(temp);
        w.target_value        = 32'(target);
        return w;
    endfunction

    function automatic in_word_t make_random_word();
        in_word_t w;
        int       pick;
        int       shape;
        w = pack_word(MODE_TICK, $urandom_range(0, 8191), $urandom_range(0, 65535),
                      $urandom_range(0, 65535), $urandom_range(0, 255), $urandom);
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            w.mode = MODE_FEEDBACK;
            shape  = $urandom_range(0, 9);
            if (shape == 0)
                sweep_angle = $urandom_range(0, 8191);
            else if (shape == 1)
                sweep_angle = $urandom_range(0, 1) ? 8191 : 0;
            else if (shape == 2)
                sweep_angle = sweep_angle + ($urandom_range(0, 1) ? 1 : -1)
                            * $urandom_range(4150, 4250);
            else
                sweep_angle = sweep_angle + $urandom_range(0, 1200) - 600;
            sweep_angle = ((sweep_angle % 8192) + 8192) % 8192;
            w.angle_reading = 13'(sweep_angle);
        end
        else if (pick < 75)
            w.mode = MODE_TICK;
        else
        begin
            w.mode = (pick < 88) ? MODE_ADD : MODE_SET;
            if ($urandom_range(0, 1))
                w.target_value = 32'($urandom_range(0, 40000)) - 32'sd20000;
        end
        return w;
    endfunction

    task automatic offer_word(input in_word_t w);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 10);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic offer_ticks(input int count);
        repeat (count)
            offer_word(pack_word(MODE_TICK, $urandom_range(0, 8191),
                                 $urandom_range(0, 65535), $urandom_range(0, 65535),
                                 $urandom_range(0, 255), $urandom));
    endtask

    task automatic drain_tracker();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (outstanding == 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_offline_limit(input logic [7:0] limit);
        drain_tracker();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= limit;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        limit_now = limit;
        @(posedge clk);
    endtask

    task automatic run_random_phase(input int count);
        int sent;
        int run_max;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                // run of ticks, at times long enough to time out the link
                run_max = (limit_now < 57) ? int'(limit_now) + 3 : 60;
                run_max = $urandom_range(1, run_max);
                offer_ticks(run_max);
                sent += run_max;
            end
            else
            begin
                offer_word(make_random_word());
                sent++;
            end
        end
    endtask

    initial
    begin
        int stall_cycles;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall_cycles = calm ? 0 : $urandom_range(0, 10);
            if (hold_request > 0)
            begin
                stall_cycles = hold_request;
                hold_request = 0;
            end
            @(negedge clk);
            if (stall_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_cycles) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial
    begin
        #3000000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        in_valid     = 1'b0;
        in_data      = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        rst_n        = 1'b0;
        calm         = 1'b0;
        hold_request = 0;
        sweep_angle  = 0;
        limit_now    = OFFLINE_LIMIT_RESET;

        // target extremes and floor split while the link is still disabled
        opening_words.push_back(pack_word(MODE_SET, 0, 0, 0, 0, 32'h7FFF_FFFF));
        opening_words.push_back(pack_word(MODE_ADD, 0, 0, 0, 0, 1));
        opening_words.push_back(pack_word(MODE_ADD, 0, 0, 0, 0, 32'h8000_0000));
        opening_words.push_back(pack_word(MODE_SET, 0, 0, 0, 0, 32'h8000_0000));
        opening_words.push_back(pack_word(MODE_ADD, 0, 0, 0, 0, -1));
        // first frame against zero, then jumps around the wrap threshold
        opening_words.push_back(pack_word(MODE_FEEDBACK, 8191, 16'h8000, 16'h7FFF, 255, 0));
        opening_words.push_back(pack_word(MODE_FEEDBACK, 0, 16'h7FFF, 16'h8000, 0, -1));
        opening_words.push_back(pack_word(MODE_FEEDBACK, 4191, 0, 0, 0, 0));
        opening_words.push_back(pack_word(MODE_FEEDBACK, 0, 0, 0, 0, 0));
        opening_words.push_back(pack_word(MODE_FEEDBACK, 4192, 0, 0, 0, 0));
        opening_words.push_back(pack_word(MODE_FEEDBACK, 0, 0, 0, 0, 0));
        opening_words.push_back(pack_word(MODE_TICK, 0, 0, 0, 0, 0));

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening_words[i])
            offer_word(opening_words[i]);

        // timeout, repeated timeout, recapture after disconnect
        write_offline_limit(8'd2);
        offer_ticks(3);
        offer_ticks(1);
        offer_word(pack_word(MODE_FEEDBACK, 100, 1234, -1234, 77, 0));
        offer_word(pack_word(MODE_ADD, 0, 0, 0, 0, 8192 * 3 + 5));
        offer_ticks(1);
        offer_word(pack_word(MODE_SET, 0, 0, 0, 0, -1));
        offer_word(pack_word(MODE_FEEDBACK, 8000, 0, 0, 0, 0));

        run_random_phase(60);

        write_offline_limit(8'd0);
        calm = 1'b1;
        run_random_phase(50);
        calm = 1'b0;

        write_offline_limit(OFFLINE_LIMIT_RESET);
        hold_request = 80;
        run_random_phase(40);
        drain_tracker();
        run_random_phase(40);

        write_offline_limit(8'd254);
        calm = 1'b1;
        offer_ticks(258);
        calm = 1'b0;
        run_random_phase(20);

        write_offline_limit(8'd255);
        offer_ticks(30);
        run_random_phase(40);

        write_offline_limit(8'($urandom_range(1, 20)));
        run_random_phase(60);

        drain_tracker();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
